// File: rtl/mtsd_pkg.sv
// shared types, codes and constants of the multitouch swipe detector
package mtsd_pkg;

    localparam int CONTACTS_DEF = 8;

    // item commands
    localparam logic [1:0] CMD_EVENT   = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_CLICK   = 2'd2;
    localparam logic [1:0] CMD_RELEASE = 2'd3;

    // event types and axis codes
    localparam logic [15:0] EV_TYPE_ABS   = 16'd3;
    localparam logic [15:0] EV_TYPE_RAW   = 16'd4;
    localparam logic [15:0] EV_CODE_SLOT  = 16'd47;
    localparam logic [15:0] EV_CODE_MAJ   = 16'd48;
    localparam logic [15:0] EV_CODE_MIN   = 16'd49;
    localparam logic [15:0] EV_CODE_ORI   = 16'd52;
    localparam logic [15:0] EV_CODE_X     = 16'd53;
    localparam logic [15:0] EV_CODE_Y     = 16'd54;
    localparam logic [15:0] EV_CODE_TRACK = 16'd57;

    localparam logic [7:0] RAW_MASK = 8'hf0;
    localparam logic [7:0] RAW_DOWN = 8'h40;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [1:0] CFG_MASK      = 2'd2;

    localparam logic [15:0] THRESHOLD_RST = 16'd100;
    localparam logic [15:0] TIMEOUT_RST   = 16'd500;

    // contact flag bits
    localparam int FL_DOWN  = 0;
    localparam int FL_XSET  = 1;
    localparam int FL_YSET  = 2;
    localparam int FL_NEW   = 3;
    localparam int FL_GEST  = 4;
    localparam int FL_IGN   = 5;
    localparam int FL_CLICK = 6;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        ev_type;
        logic [15:0]        ev_code;
        logic signed [31:0] ev_value;
        logic [31:0]        time_ms;
    } in_item_t;

    typedef struct packed {
        logic       swipe_right;
        logic       swipe_left;
        logic       swipe_down;
        logic       swipe_up;
        logic [1:0] swipe_fingers;
        logic [3:0] contact_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_TICK_A,
        ST_TICK_B,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec_item;
        logic clr_idx;
        logic inc_idx;
        logic tick_a;
        logic tick_b;
        logic decide;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic idx_last;
        logic out_full;
    } dp_sts_t;

endpackage

// File: rtl/multitouch_swipe_detector.sv
// Multitouch swipe detector: tracks touch contacts and flags one- and
// two-finger swipes.
//
// Input channel s_valid/s_ready/s_item carries event, tick, click and
// click-release items; every accepted item yields exactly one result on
// m_valid/m_ready/m_item with the swipe flags, finger count and the number
// of held contacts.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data and are
// always taken; write only while the block is idle.
// Event, click and release items run once and then load their result; a
// tick walks the contact table through the TICK_A and TICK_B states per
// contact, then passes through DECIDE and FINISH. One item is worked on at a
// time, and s_ready rises again once the result is loaded.
// The result register lets the next item in while a result waits; if the
// receiver stalls with a result still held, the item finished after it
// waits in the controller until the register drains.
// Reset (aresetn low, synchronous) frees all contacts, deselects the slot
// and restores the configuration defaults.
module multitouch_swipe_detector #(
    parameter int CONTACTS = mtsd_pkg::CONTACTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  mtsd_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output mtsd_pkg::out_item_t m_item
);
    import mtsd_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    assign cfg_ready = 1'b1;

    mtsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (dp_cmd)
    );

    mtsd_datapath #(
        .CONTACTS (CONTACTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_item    (s_item),
        .m_ready   (m_ready),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .m_valid   (m_valid),
        .m_item    (m_item)
    );

endmodule

// File: rtl/mtsd_ctrl.sv
// sequencing state machine of the swipe detector
module mtsd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mtsd_pkg::dp_sts_t sts,
    output mtsd_pkg::dp_cmd_t cmd
);
    import mtsd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sts.is_tick) begin
                    cmd.clr_idx = 1'b1;
                    state_next  = ST_TICK_A;
                end else begin
                    cmd.exec_item = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_TICK_A: begin
                cmd.tick_a = 1'b1;
                state_next = ST_TICK_B;
            end
            ST_TICK_B: begin
                cmd.tick_b = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_DECIDE;
                end else begin
                    cmd.inc_idx = 1'b1;
                    state_next  = ST_TICK_A;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for the output register to drain
                if (!sts.out_full) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mtsd_datapath.sv
// contact table, configuration registers and swipe arithmetic
module mtsd_datapath #(
    parameter int CONTACTS = mtsd_pkg::CONTACTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  mtsd_pkg::in_item_t  s_item,
    input  logic                m_ready,
    input  mtsd_pkg::dp_cmd_t   cmd,
    output mtsd_pkg::dp_sts_t   sts,
    output logic                m_valid,
    output mtsd_pkg::out_item_t m_item
);
    import mtsd_pkg::*;

    localparam int IW = (CONTACTS > 1) ? $clog2(CONTACTS) : 1;
    localparam int CW = $clog2(CONTACTS + 1);

    logic signed [31:0] slot_reg   [CONTACTS];
    logic signed [31:0] track_reg  [CONTACTS];
    logic [6:0]         flags_reg  [CONTACTS];
    logic signed [31:0] ox_reg     [CONTACTS];
    logic signed [31:0] oy_reg     [CONTACTS];
    logic signed [31:0] nx_reg     [CONTACTS];
    logic signed [31:0] ny_reg     [CONTACTS];
    logic signed [31:0] gx_reg     [CONTACTS];
    logic signed [31:0] gy_reg     [CONTACTS];
    logic [31:0]        seen_reg   [CONTACTS];

    logic signed [31:0] sel_slot_reg;
    in_item_t           item_reg;
    logic [15:0]        thr_reg;
    logic [15:0]        tmo_reg;
    logic [7:0]         mask_reg;
    logic [IW-1:0]      idx_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic               eval_reg;
    logic [CW-1:0]      cnt_reg    [4];
    logic [CW-1:0]      held_cnt_reg;
    logic [3:0]         dir_reg;
    logic [1:0]         fing_reg;
    logic               m_valid_reg;
    out_item_t          m_item_reg;

    // parallel lookup of selected contact and first free entry
    logic          sel_found, free_found;
    logic [IW-1:0] sel_idx, free_idx;

    always_comb begin
        sel_found  = 1'b0;
        sel_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CONTACTS - 1; i >= 0; i--) begin
            if (!slot_reg[i][31] && !sel_slot_reg[31] && slot_reg[i] == sel_slot_reg) begin
                sel_found = 1'b1;
                sel_idx   = IW'(i);
            end
            if (slot_reg[i][31]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // per contact tick evaluation at idx_reg
    logic               ta_active, ta_free, ta_click;
    logic [31:0]        ta_diff;
    logic signed [32:0] ta_dx, ta_dy;

    always_comb begin
        ta_active = !slot_reg[idx_reg][31] && !flags_reg[idx_reg][FL_IGN]
                    && flags_reg[idx_reg][FL_DOWN];
        ta_click  = flags_reg[idx_reg][FL_CLICK];
        ta_diff   = item_reg.time_ms - seen_reg[idx_reg];
        ta_free   = track_reg[idx_reg][31]
                    || (!ta_click && !ta_diff[31] && ta_diff > {16'd0, tmo_reg});
        if (flags_reg[idx_reg][FL_GEST]) begin
            ta_dx = {nx_reg[idx_reg][31], nx_reg[idx_reg]}
                    - {gx_reg[idx_reg][31], gx_reg[idx_reg]};
            ta_dy = {ny_reg[idx_reg][31], ny_reg[idx_reg]}
                    - {gy_reg[idx_reg][31], gy_reg[idx_reg]};
        end else begin
            ta_dx = {nx_reg[idx_reg][31], nx_reg[idx_reg]}
                    - {ox_reg[idx_reg][31], ox_reg[idx_reg]};
            ta_dy = {ny_reg[idx_reg][31], ny_reg[idx_reg]}
                    - {oy_reg[idx_reg][31], oy_reg[idx_reg]};
        end
    end

    // threshold compares on registered displacement
    logic signed [32:0] thr_pos, thr_neg;
    logic [3:0]         hit;

    always_comb begin
        thr_pos = $signed({17'd0, thr_reg});
        thr_neg = -thr_pos;
        hit[0]  = dx_reg > thr_pos;
        hit[1]  = dx_reg < thr_neg;
        hit[2]  = dy_reg > thr_pos;
        hit[3]  = dy_reg < thr_neg;
    end

    // swipe decision from direction counts
    logic [3:0] qual;
    logic       any_qual, ign_set;

    always_comb begin
        ign_set = 1'b0;
        for (int d = 0; d < 4; d++) begin
            qual[d] = (cnt_reg[d] != '0) && (cnt_reg[d] == held_cnt_reg)
                      && (held_cnt_reg <= CW'(2));
            if (qual[d]) begin
                ign_set = ign_set | ((held_cnt_reg == CW'(1)) ? mask_reg[2*d]
                                                              : mask_reg[2*d+1]);
            end
        end
        any_qual = |qual;
    end

    logic [31:0]        ev_t;
    logic signed [31:0] ev_v;

    assign ev_t = item_reg.time_ms;
    assign ev_v = item_reg.ev_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CONTACTS; i++) begin
                slot_reg[i]  <= -32'sd1;
                track_reg[i] <= -32'sd1;
                flags_reg[i] <= '0;
                ox_reg[i]    <= '0;
                oy_reg[i]    <= '0;
                nx_reg[i]    <= '0;
                ny_reg[i]    <= '0;
                gx_reg[i]    <= '0;
                gy_reg[i]    <= '0;
                seen_reg[i]  <= '0;
            end
            sel_slot_reg <= -32'sd1;
            thr_reg      <= THRESHOLD_RST;
            tmo_reg      <= TIMEOUT_RST;
            mask_reg     <= '0;
            held_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            idx_reg      <= '0;
            eval_reg     <= 1'b0;
            dir_reg      <= '0;
            fing_reg     <= '0;
            for (int d = 0; d < 4; d++) begin
                cnt_reg[d] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_THRESHOLD: thr_reg  <= cfg_data;
                    CFG_TIMEOUT:   tmo_reg  <= cfg_data;
                    CFG_MASK:      mask_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (cmd.load_in) begin
                item_reg <= s_item;
                dir_reg  <= '0;
                fing_reg <= '0;
                eval_reg <= 1'b0;
                for (int d = 0; d < 4; d++) begin
                    cnt_reg[d] <= '0;
                end
            end

            if (cmd.exec_item) begin
                case (item_reg.cmd)
                    CMD_EVENT: begin
                        if (item_reg.ev_type == EV_TYPE_RAW) begin
                            if (sel_found) begin
                                flags_reg[sel_idx][FL_DOWN] <=
                                    ((ev_v[7:0] & RAW_MASK) == RAW_DOWN);
                                seen_reg[sel_idx] <= ev_t;
                            end
                        end else if (item_reg.ev_type == EV_TYPE_ABS) begin
                            if (item_reg.ev_code == EV_CODE_SLOT) begin
                                sel_slot_reg <= ev_v;
                            end else if (item_reg.ev_code == EV_CODE_MAJ
                                         || item_reg.ev_code == EV_CODE_MIN
                                         || item_reg.ev_code == EV_CODE_ORI) begin
                                if (sel_found) begin
                                    seen_reg[sel_idx] <= ev_t;
                                end
                            end else if (item_reg.ev_code == EV_CODE_X) begin
                                if (sel_found && flags_reg[sel_idx][FL_DOWN]) begin
                                    if (!flags_reg[sel_idx][FL_XSET]) begin
                                        ox_reg[sel_idx] <= ev_v;
                                        gx_reg[sel_idx] <= ev_v;
                                    end
                                    nx_reg[sel_idx]            <= ev_v;
                                    flags_reg[sel_idx][FL_XSET] <= 1'b1;
                                    seen_reg[sel_idx]          <= ev_t;
                                end
                            end else if (item_reg.ev_code == EV_CODE_Y) begin
                                if (sel_found && flags_reg[sel_idx][FL_DOWN]) begin
                                    if (!flags_reg[sel_idx][FL_YSET]) begin
                                        oy_reg[sel_idx] <= ev_v;
                                        gy_reg[sel_idx] <= ev_v;
                                    end
                                    ny_reg[sel_idx]            <= ev_v;
                                    flags_reg[sel_idx][FL_YSET] <= 1'b1;
                                    seen_reg[sel_idx]          <= ev_t;
                                end
                            end else if (item_reg.ev_code == EV_CODE_TRACK) begin
                                if (ev_v == -32'sd1) begin
                                    if (sel_found) begin
                                        slot_reg[sel_idx]  <= -32'sd1;
                                        track_reg[sel_idx] <= -32'sd1;
                                        flags_reg[sel_idx] <= '0;
                                        ox_reg[sel_idx]    <= '0;
                                        oy_reg[sel_idx]    <= '0;
                                        nx_reg[sel_idx]    <= '0;
                                        ny_reg[sel_idx]    <= '0;
                                        gx_reg[sel_idx]    <= '0;
                                        gy_reg[sel_idx]    <= '0;
                                        seen_reg[sel_idx]  <= '0;
                                        held_cnt_reg       <= held_cnt_reg - CW'(1);
                                    end
                                end else if (sel_found) begin
                                    track_reg[sel_idx] <= ev_v;
                                    seen_reg[sel_idx]  <= ev_t;
                                end else if (!sel_slot_reg[31] && free_found) begin
                                    // new contact in the first free entry
                                    slot_reg[free_idx]          <= sel_slot_reg;
                                    flags_reg[free_idx][FL_NEW] <= 1'b1;
                                    track_reg[free_idx]         <= ev_v;
                                    seen_reg[free_idx]          <= ev_t;
                                    held_cnt_reg                <= held_cnt_reg + CW'(1);
                                end
                            end
                        end
                    end
                    CMD_CLICK: begin
                        if (sel_found) begin
                            flags_reg[sel_idx][FL_CLICK] <= 1'b1;
                        end
                    end
                    CMD_RELEASE: begin
                        for (int i = 0; i < CONTACTS; i++) begin
                            flags_reg[i][FL_CLICK] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            if (cmd.clr_idx) begin
                idx_reg <= '0;
            end else if (cmd.inc_idx) begin
                idx_reg <= idx_reg + IW'(1);
            end

            if (cmd.tick_a) begin
                eval_reg <= 1'b0;
                if (ta_active) begin
                    if (ta_free) begin
                        slot_reg[idx_reg]  <= -32'sd1;
                        track_reg[idx_reg] <= -32'sd1;
                        flags_reg[idx_reg] <= '0;
                        ox_reg[idx_reg]    <= '0;
                        oy_reg[idx_reg]    <= '0;
                        nx_reg[idx_reg]    <= '0;
                        ny_reg[idx_reg]    <= '0;
                        gx_reg[idx_reg]    <= '0;
                        gy_reg[idx_reg]    <= '0;
                        seen_reg[idx_reg]  <= '0;
                        held_cnt_reg       <= held_cnt_reg - CW'(1);
                    end else begin
                        if (ta_click) begin
                            seen_reg[idx_reg] <= ev_t;
                        end
                        dx_reg   <= ta_dx;
                        dy_reg   <= ta_dy;
                        eval_reg <= 1'b1;
                    end
                end
            end

            if (cmd.tick_b && eval_reg) begin
                for (int d = 0; d < 4; d++) begin
                    if (hit[d]) begin
                        cnt_reg[d] <= cnt_reg[d] + CW'(1);
                    end
                end
            end

            if (cmd.decide && any_qual) begin
                dir_reg  <= qual;
                fing_reg <= held_cnt_reg[1:0];
                // rebase every held contact
                for (int i = 0; i < CONTACTS; i++) begin
                    if (!slot_reg[i][31]) begin
                        flags_reg[i][FL_GEST] <= 1'b1;
                        if (ign_set) begin
                            flags_reg[i][FL_IGN] <= 1'b1;
                        end
                        gx_reg[i] <= nx_reg[i];
                        gy_reg[i] <= ny_reg[i];
                    end
                end
            end

            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_item_reg.swipe_right   <= dir_reg[0];
            m_item_reg.swipe_left    <= dir_reg[1];
            m_item_reg.swipe_down    <= dir_reg[2];
            m_item_reg.swipe_up      <= dir_reg[3];
            m_item_reg.swipe_fingers <= fing_reg;
            m_item_reg.contact_count <= 4'(held_cnt_reg);
        end
    end

    assign sts.is_tick  = (item_reg.cmd == CMD_TICK);
    assign sts.idx_last = (idx_reg == IW'(CONTACTS - 1));
    assign sts.out_full = m_valid_reg;
    assign m_valid      = m_valid_reg;
    assign m_item       = m_item_reg;

endmodule

// File: rtl/mtsd_checker.sv
// port level checks of the swipe detector and their binding
module mtsd_props (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mtsd_pkg::out_item_t m_item
);
    import mtsd_pkg::*;

    // a held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_fingers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.swipe_fingers != 2'd0) ==
                     (m_item.swipe_right || m_item.swipe_left ||
                      m_item.swipe_down || m_item.swipe_up)))
        else $error("finger count disagrees with swipe flags");

    // every held contact took part in a swipe
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.swipe_fingers != 2'd0 |->
            m_item.contact_count == {2'd0, m_item.swipe_fingers})
        else $error("swipe finger count differs from held contacts");

endmodule

bind multitouch_swipe_detector mtsd_props u_mtsd_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// File: tb/sv/mtsd_checker.sv
// checker: predicts swipe results from observed items and compares them
module mtsd_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  mtsd_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  mtsd_pkg::out_item_t m_item,
    output int                  fail_count,
    output int                  pending
);
    import mtsd_pkg::*;

    localparam int NC = CONTACTS_DEF;

    logic [15:0] thr_q;
    logic [15:0] tmo_q;
    logic [7:0]  mask_q;

    logic signed [31:0] slot_q  [NC];
    logic signed [31:0] track_q [NC];
    logic [6:0]         flags_q [NC];
    logic signed [31:0] ox_q [NC];
    logic signed [31:0] oy_q [NC];
    logic signed [31:0] nx_q [NC];
    logic signed [31:0] ny_q [NC];
    logic signed [31:0] gx_q [NC];
    logic signed [31:0] gy_q [NC];
    logic [31:0]        seen_q [NC];
    logic signed [31:0] sel_slot;
    logic [31:0]        ev_ms;

    out_item_t swipe_queue[$];

    assign pending = swipe_queue.size();

    function automatic void drop_contact(int i);
        slot_q[i] = -1;
        track_q[i] = -1;
        flags_q[i] = '0;
        ox_q[i] = 0; oy_q[i] = 0; nx_q[i] = 0; ny_q[i] = 0;
        gx_q[i] = 0; gy_q[i] = 0;
        seen_q[i] = '0;
    endfunction

    function automatic int find_selected();
        if (sel_slot < 0) return -1;
        for (int i = 0; i < NC; i++)
            if (slot_q[i] == sel_slot) return i;
        return -1;
    endfunction

    function automatic int held();
        int n;
        n = 0;
        for (int i = 0; i < NC; i++)
            if (slot_q[i] >= 0) n++;
        return n;
    endfunction

    function automatic void apply_event(in_item_t it);
        int c;
        c = find_selected();
        ev_ms = it.time_ms;
        if (it.ev_type == EV_TYPE_RAW) begin
            if (c >= 0) begin
                flags_q[c][FL_DOWN] = ((it.ev_value[7:0] & RAW_MASK) == RAW_DOWN);
                seen_q[c] = ev_ms;
            end
        end else if (it.ev_type == EV_TYPE_ABS) begin
            case (it.ev_code)
                EV_CODE_SLOT: sel_slot = it.ev_value;
                EV_CODE_MAJ, EV_CODE_MIN, EV_CODE_ORI: begin
                    if (c >= 0) seen_q[c] = ev_ms;
                end
                EV_CODE_X, EV_CODE_Y: begin
                    if (c >= 0 && flags_q[c][FL_DOWN]) begin
                        if (it.ev_code == EV_CODE_X) begin
                            if (!flags_q[c][FL_XSET]) begin
                                ox_q[c] = it.ev_value; gx_q[c] = it.ev_value;
                            end
                            nx_q[c] = it.ev_value;
                            flags_q[c][FL_XSET] = 1'b1;
                        end else begin
                            if (!flags_q[c][FL_YSET]) begin
                                oy_q[c] = it.ev_value; gy_q[c] = it.ev_value;
                            end
                            ny_q[c] = it.ev_value;
                            flags_q[c][FL_YSET] = 1'b1;
                        end
                        seen_q[c] = ev_ms;
                    end
                end
                EV_CODE_TRACK: begin
                    if (it.ev_value == -1) begin
                        if (c >= 0) drop_contact(c);
                    end else if (sel_slot >= 0 && c < 0) begin
                        for (int i = 0; i < NC; i++) begin
                            if (slot_q[i] < 0) begin
                                slot_q[i] = sel_slot;
                                flags_q[i][FL_NEW] = 1'b1;
                                break;
                            end
                        end
                    end
                    c = find_selected();
                    if (c >= 0) begin
                        track_q[c] = it.ev_value;
                        seen_q[c] = ev_ms;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void apply_tick(logic [31:0] t, ref out_item_t r);
        int cnt [4];
        int n;
        logic signed [33:0] dx, dy, th;
        logic [31:0] diff;
        cnt = '{0, 0, 0, 0};
        th = $signed({18'd0, thr_q});
        for (int i = 0; i < NC; i++) begin
            if (slot_q[i] < 0 || flags_q[i][FL_IGN] || !flags_q[i][FL_DOWN]) continue;
            if (track_q[i] < 0) begin
                drop_contact(i);
                continue;
            end
            if (flags_q[i][FL_CLICK]) begin
                seen_q[i] = t;
            end else begin
                diff = t - seen_q[i];
                if (!diff[31] && diff > {16'd0, tmo_q}) begin
                    drop_contact(i);
                    continue;
                end
            end
            if (flags_q[i][FL_GEST]) begin
                dx = 34'(nx_q[i]) - 34'(gx_q[i]);
                dy = 34'(ny_q[i]) - 34'(gy_q[i]);
            end else begin
                dx = 34'(nx_q[i]) - 34'(ox_q[i]);
                dy = 34'(ny_q[i]) - 34'(oy_q[i]);
            end
            if (dx > th) cnt[0]++;
            if (dx < -th) cnt[1]++;
            if (dy > th) cnt[2]++;
            if (dy < -th) cnt[3]++;
        end
        n = held();
        for (int d = 0; d < 4; d++) begin
            if (cnt[d] == 0 || cnt[d] != n || n > 2) continue;
            case (d)
                0: r.swipe_right = 1'b1;
                1: r.swipe_left = 1'b1;
                2: r.swipe_down = 1'b1;
                default: r.swipe_up = 1'b1;
            endcase
            r.swipe_fingers = 2'(n);
            for (int i = 0; i < NC; i++) begin
                if (slot_q[i] < 0) continue;
                flags_q[i][FL_GEST] = 1'b1;
                gx_q[i] = nx_q[i];
                gy_q[i] = ny_q[i];
                if (mask_q[2 * d + n - 1]) flags_q[i][FL_IGN] = 1'b1;
            end
        end
    endfunction

    function automatic out_item_t predict_swipe(in_item_t it);
        out_item_t r;
        int c;
        r = '0;
        case (it.cmd)
            CMD_EVENT: apply_event(it);
            CMD_TICK:  apply_tick(it.time_ms, r);
            CMD_CLICK: begin
                c = find_selected();
                if (c >= 0) flags_q[c][FL_CLICK] = 1'b1;
            end
            default: begin
                for (int i = 0; i < NC; i++) flags_q[i][FL_CLICK] = 1'b0;
            end
        endcase
        r.contact_count = 4'(held());
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t exp_item;
        if (!aresetn) begin
            thr_q <= THRESHOLD_RST;
            tmo_q <= TIMEOUT_RST;
            mask_q <= '0;
            for (int i = 0; i < NC; i++) drop_contact(i);
            sel_slot = -1;
            ev_ms = '0;
            swipe_queue.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_THRESHOLD: thr_q <= cfg_data;
                    CFG_TIMEOUT:   tmo_q <= cfg_data;
                    CFG_MASK:      mask_q <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) swipe_queue.push_back(predict_swipe(s_item));
            if (m_valid && m_ready) begin
                if (swipe_queue.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %p", $time, m_item);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_item = swipe_queue.pop_front();
                    if (exp_item !== m_item) begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, exp_item, m_item);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_multitouch_swipe_detector.sv
// testbench top: drives touch stimulus and configuration, gives the verdict
module tb_multitouch_swipe_detector;
    import mtsd_pkg::*;

    localparam int LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;
    int fail_count;
    int pending;
    int cycles = 0;
    bit calm = 1'b0;
    bit hold_rx = 1'b0;
    logic [31:0] clock_ms = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    multitouch_swipe_detector DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    mtsd_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stalls at random, or for a long hold-off on request
    always @(posedge aclk) begin
        if (hold_rx) m_ready <= 1'b0;
        else m_ready <= calm || ($urandom_range(99) >= 15);
    end

    task automatic send_item(in_item_t it);
        if (!calm) begin
            while ($urandom_range(99) < 15) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send_touch(logic [1:0] cmd, logic [15:0] ty, logic [15:0] code,
                              logic [31:0] val);
        in_item_t it;
        clock_ms = clock_ms + $urandom_range(40);
        it.cmd = cmd;
        it.ev_type = ty;
        it.ev_code = code;
        it.ev_value = val;
        it.time_ms = clock_ms;
        send_item(it);
    endtask

    task automatic abs_event(logic [15:0] code, logic [31:0] val);
        send_touch(CMD_EVENT, EV_TYPE_ABS, code, val);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // touch down in a slot, travel and tick: a well-formed swipe
    task automatic swipe_seq(int fingers);
        int slots [2];
        int sx, sy, vx, vy;
        vx = $urandom_range(1) ? int'($urandom_range(400)) - 200 : 0;
        vy = $urandom_range(1) ? int'($urandom_range(400)) - 200 : 0;
        for (int f = 0; f < fingers; f++) begin
            slots[f] = $urandom_range(9);
            abs_event(EV_CODE_SLOT, slots[f]);
            abs_event(EV_CODE_TRACK, $urandom_range(1000));
            send_touch(CMD_EVENT, EV_TYPE_RAW, 16'd0, 32'h40 | $urandom_range(15));
            sx = $urandom_range(2000);
            sy = $urandom_range(2000);
            abs_event(EV_CODE_X, sx);
            abs_event(EV_CODE_Y, sy);
            abs_event(EV_CODE_X, sx + vx);
            abs_event(EV_CODE_Y, sy + vy);
        end
        send_touch(CMD_TICK, '0, '0, $urandom);
        if ($urandom_range(3) == 0) send_touch(CMD_CLICK, '0, '0, '0);
        send_touch(CMD_TICK, '0, '0, $urandom);
        for (int f = 0; f < fingers; f++) begin
            if ($urandom_range(2) != 0) begin
                abs_event(EV_CODE_SLOT, slots[f]);
                abs_event(EV_CODE_TRACK, 32'hffffffff);
            end
        end
    endtask

    task automatic noise_item();
        logic [15:0] codes [9];
        in_item_t it;
        codes = '{EV_CODE_SLOT, EV_CODE_MAJ, EV_CODE_MIN, EV_CODE_ORI, EV_CODE_X,
                  EV_CODE_Y, EV_CODE_TRACK, 16'd0, 16'hffff};
        it.cmd = 2'($urandom_range(3));
        it.ev_type = $urandom_range(3) == 0 ? 16'($urandom) :
                     ($urandom_range(1) ? EV_TYPE_ABS : EV_TYPE_RAW);
        it.ev_code = $urandom_range(4) == 0 ? 16'($urandom) : codes[$urandom_range(8)];
        case ($urandom_range(3))
            0: it.ev_value = $urandom;
            1: it.ev_value = int'($urandom_range(12)) - 2;
            default: it.ev_value = $urandom_range(3000);
        endcase
        clock_ms = $urandom_range(9) == 0 ? $urandom : clock_ms + $urandom_range(700);
        it.time_ms = clock_ms;
        send_item(it);
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) < 6) begin
                swipe_seq($urandom_range(3) == 0 ? 2 : 1);
                n += 12;
            end else begin
                noise_item();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every command, frees and timeouts
        abs_event(EV_CODE_TRACK, 32'd5);
        abs_event(EV_CODE_SLOT, 32'd0);
        abs_event(EV_CODE_TRACK, 32'd7);
        send_touch(CMD_EVENT, EV_TYPE_RAW, 16'd0, 32'h4f);
        abs_event(EV_CODE_X, 32'h7fffffff);
        abs_event(EV_CODE_Y, 32'h80000000);
        abs_event(EV_CODE_X, 32'h80000000);
        send_touch(CMD_TICK, '0, '0, '0);
        send_touch(CMD_CLICK, '0, '0, '0);
        send_touch(CMD_TICK, 16'hffff, 16'hffff, 32'hffffffff);
        send_touch(CMD_RELEASE, '0, '0, '0);
        abs_event(EV_CODE_MAJ, 32'd1);
        abs_event(EV_CODE_MIN, 32'd1);
        abs_event(EV_CODE_ORI, 32'd1);
        send_touch(CMD_EVENT, EV_TYPE_RAW, 16'd0, 32'h30);
        abs_event(EV_CODE_X, 32'd9);
        abs_event(EV_CODE_SLOT, 32'd1);
        abs_event(EV_CODE_TRACK, 32'h80000000);
        send_touch(CMD_EVENT, EV_TYPE_RAW, 16'd0, 32'h40);
        send_touch(CMD_TICK, '0, '0, clock_ms);
        abs_event(EV_CODE_SLOT, 32'd0);
        abs_event(EV_CODE_TRACK, 32'hffffffff);
        send_touch(CMD_EVENT, 16'hffff, 16'hffff, 32'h7fffffff);
        clock_ms = 32'hffff0000;
        send_touch(CMD_TICK, '0, '0, clock_ms);
        drain();

        write_reg(CFG_THRESHOLD, 16'd0);
        write_reg(CFG_TIMEOUT, 16'hffff);
        write_reg(CFG_MASK, 16'h00ff);
        random_phase(120);

        // long receiver hold-off while the sender keeps going
        hold_rx = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_rx = 1'b0;
            end
            random_phase(30);
        join
        drain();

        write_reg(CFG_THRESHOLD, 16'hffff);
        write_reg(CFG_TIMEOUT, 16'd0);
        write_reg(CFG_MASK, 16'h0000);
        random_phase(60);
        drain();

        write_reg(CFG_THRESHOLD, 16'd150);
        write_reg(CFG_TIMEOUT, 16'd300);
        write_reg(CFG_MASK, 16'($urandom_range(255)));
        calm = 1'b1;
        random_phase(100);
        calm = 1'b0;
        drain();

        write_reg(CFG_THRESHOLD, 16'($urandom_range(300)));
        write_reg(CFG_TIMEOUT, 16'($urandom));
        write_reg(CFG_MASK, 16'($urandom_range(255)));
        random_phase(220);

        drain();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
